// ===== rtl/rtpjb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rtpjb_pkg;

    localparam int MAX_DEPTH      = 8;
    localparam int MAX_STREAMS    = 16;
    localparam int DEFAULT_STAGES = 2;

    localparam int SW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW    = $clog2(MAX_DEPTH + 1);
    localparam int PW    = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int LW    = $clog2(MAX_STREAMS + 1);
    localparam int NSLOT = MAX_DEPTH * MAX_STREAMS;
    localparam int AW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int CFGW  = 4;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_POP = 1'b1;

    localparam logic [2:0] K_STORED = 3'd0;
    localparam logic [2:0] K_DUP    = 3'd1;
    localparam logic [2:0] K_DROP   = 3'd2;
    localparam logic [2:0] K_REL    = 3'd3;
    localparam logic [2:0] K_EMPTY  = 3'd4;
    localparam logic [2:0] K_FULL   = 3'd5;

    localparam logic [1:0] SRC_IN   = 2'd0;
    localparam logic [1:0] SRC_RD   = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_DROP = 2'd3;

    typedef struct packed {
        logic [31:0] stream;
        logic [15:0] seq;
        logic [15:0] tag;
    } t_frame;

    typedef struct packed {
        logic          in_load;
        logic [CW-1:0] cur_stage;
        logic          rd_en;
        logic [CW-1:0] rd_stage;
        logic [LW-1:0] rd_pos;
        logic          wr_en;
        logic [CW-1:0] wr_stage;
        logic [LW-1:0] wr_pos;
        logic [1:0]    wr_src;
        logic          len_inc;
        logic          cnt_set;
        logic          pop_stage;
        logic          drop_load;
        logic          out_load;
        logic [2:0]    out_kind;
        logic [1:0]    out_src;
        logic          out_last;
    } t_cmd;

    typedef struct packed {
        logic          op;
        logic          stream_gt;
        logic          stream_eq;
        logic          seq_gt;
        logic          seq_eq;
        logic [LW-1:0] len;
        logic [CW-1:0] count;
        logic [CW-1:0] limit;
        logic          out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/rtpjb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rtpjb_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] stream_id;
    logic [15:0] seq_num;
    logic [15:0] frame_tag;
    modport source (output valid, op, stream_id, seq_num, frame_tag, input ready);
    modport sink (input valid, op, stream_id, seq_num, frame_tag, output ready);
endinterface

interface rtpjb_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] out_stream_id;
    logic [15:0] out_seq_num;
    logic [15:0] out_tag;
    logic        last;
    modport source (output valid, kind, out_stream_id, out_seq_num, out_tag, last,
                    input ready);
    modport sink (input valid, kind, out_stream_id, out_seq_num, out_tag, last,
                  output ready);
endinterface

interface rtpjb_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] stage_cap;
    modport source (output valid, stage_cap, input ready);
    modport sink (input valid, stage_cap, output ready);
endinterface
`default_nettype wire

// ===== rtl/rtpjb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtpjb_datapath
    import rtpjb_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cmd            i_cmd,
    output t_stat                o_stat,
    input  wire logic            i_op,
    input  wire logic [31:0]     i_stream_id,
    input  wire logic [15:0]     i_seq_num,
    input  wire logic [15:0]     i_frame_tag,
    input  wire logic            i_cfg_valid,
    input  wire logic [CFGW-1:0] i_cfg_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [2:0]           o_kind,
    output logic [31:0]          o_stream_id,
    output logic [15:0]          o_seq_num,
    output logic [15:0]          o_tag,
    output logic                 o_last
);

    t_frame          r_mem [NSLOT];
    t_frame          r_in;
    logic            r_op;
    t_frame          r_rd;
    t_frame          r_drop;
    logic [CFGW-1:0] r_cfg;
    logic [LW-1:0]   r_len [MAX_DEPTH];
    logic [CW-1:0]   r_count;
    logic [SW-1:0]   r_base;
    logic            r_ovalid;
    logic [2:0]      r_okind;
    t_frame          r_oframe;
    logic            r_olast;

    logic [SW-1:0]   cur_ph;
    logic [SW-1:0]   head_ph;
    logic [SW-1:0]   next_ph;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    t_frame          wr_data;
    t_frame          out_frame;
    logic [CW-1:0]   limit;

    // logical stage to physical stage, stage 0 sits at r_base
    function automatic logic [SW-1:0] phys(input logic [CW-1:0] l, input logic [SW-1:0] b);
        logic [SW+1:0] sum;
        sum = {2'b00, b} + (SW+2)'(l);
        if (sum >= (SW+2)'(MAX_DEPTH)) begin
            sum = sum - (SW+2)'(MAX_DEPTH);
        end
        return sum[SW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] ph,
                                                input logic [LW-1:0] pos);
        return AW'(int'(ph) * MAX_STREAMS + int'(pos[PW-1:0]));
    endfunction

    assign cur_ph  = phys(i_cmd.cur_stage, r_base);
    assign head_ph = phys(CW'(0), r_base);
    assign next_ph = phys(CW'(1), r_base);
    assign rd_addr = slot_addr(phys(i_cmd.rd_stage, r_base), i_cmd.rd_pos);
    assign wr_addr = slot_addr(phys(i_cmd.wr_stage, r_base), i_cmd.wr_pos);
    assign wr_data = (i_cmd.wr_src == SRC_RD) ? r_rd : r_in;

    always_comb begin
        if (r_cfg == '0) begin
            limit = CW'(DEFAULT_STAGES);
        end else if (int'(r_cfg) > MAX_DEPTH) begin
            limit = CW'(MAX_DEPTH);
        end else begin
            limit = CW'(r_cfg);
        end
    end

    always_comb begin
        case (i_cmd.out_src)
            SRC_IN:   out_frame = r_in;
            SRC_RD:   out_frame = r_rd;
            SRC_DROP: out_frame = r_drop;
            default:  out_frame = '0;
        endcase
    end

    always_comb begin
        o_stat.op        = r_op;
        o_stat.stream_gt = r_in.stream > r_rd.stream;
        o_stat.stream_eq = r_in.stream == r_rd.stream;
        o_stat.seq_gt    = r_in.seq > r_rd.seq;
        o_stat.seq_eq    = r_in.seq == r_rd.seq;
        o_stat.len       = r_len[cur_ph];
        o_stat.count     = r_count;
        o_stat.limit     = limit;
        o_stat.out_free  = !r_ovalid || i_ready;
    end

    // frame store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_op <= i_op;
            r_in <= '{stream: i_stream_id, seq: i_seq_num, tag: i_frame_tag};
        end
        if (i_cmd.drop_load) begin
            r_drop <= r_rd;
        end
        if (i_cmd.out_load) begin
            r_okind  <= i_cmd.out_kind;
            r_oframe <= out_frame;
            r_olast  <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= CFGW'(DEFAULT_STAGES);
            r_count  <= '0;
            r_base   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < MAX_DEPTH; i++) begin
                r_len[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.len_inc) begin
                r_len[cur_ph] <= r_len[cur_ph] + LW'(1);
            end
            if (i_cmd.cnt_set) begin
                r_count <= i_cmd.cur_stage + CW'(1);
            end
            if (i_cmd.pop_stage) begin
                r_len[head_ph] <= '0;
                r_base         <= next_ph;
                r_count        <= r_count - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_ovalid;
    assign o_kind      = r_okind;
    assign o_stream_id = r_oframe.stream;
    assign o_seq_num   = r_oframe.seq;
    assign o_tag       = r_oframe.tag;
    assign o_last      = r_olast;

endmodule
`default_nettype wire

// ===== rtl/rtpjb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtpjb_ctrl
    import rtpjb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_START    = 4'd1;
    localparam logic [3:0] ST_SCAN_RD  = 4'd2;
    localparam logic [3:0] ST_SCAN_CHK = 4'd3;
    localparam logic [3:0] ST_ALL      = 4'd4;
    localparam logic [3:0] ST_SH_RD    = 4'd5;
    localparam logic [3:0] ST_SH_WR    = 4'd6;
    localparam logic [3:0] ST_MV_RD    = 4'd7;
    localparam logic [3:0] ST_MV_WR    = 4'd8;
    localparam logic [3:0] ST_DR_LD    = 4'd9;
    localparam logic [3:0] ST_DR_RD    = 4'd10;
    localparam logic [3:0] ST_DR_WR    = 4'd11;
    localparam logic [3:0] ST_POP_RD   = 4'd12;
    localparam logic [3:0] ST_POP_OUT  = 4'd13;
    localparam logic [3:0] ST_EMIT     = 4'd14;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_s, n_s;
    logic [LW-1:0] r_p, n_p;
    logic [CW-1:0] r_s0, n_s0;
    logic          r_s0_ok, n_s0_ok;
    logic [LW-1:0] r_pos [MAX_DEPTH];
    logic [LW-1:0] n_pos [MAX_DEPTH];
    logic [2:0]    r_kind, n_kind;
    logic [1:0]    r_src, n_src;

    logic [CW-1:0] eff;
    logic [CW-1:0] sm1;
    logic [CW-1:0] sp1;
    logic [CW-1:0] s0v;
    logic [SW-1:0] ix;
    logic [SW-1:0] ixm;
    logic [SW-1:0] ixp;
    logic          go_next;
    logic          go_absent;

    assign eff = (i_stat.count == '0) ? CW'(1) : i_stat.count;
    assign sm1 = r_s - CW'(1);
    assign sp1 = r_s + CW'(1);
    assign ix  = r_s[SW-1:0];
    assign ixm = sm1[SW-1:0];
    assign ixp = sp1[SW-1:0];
    assign s0v = r_s0_ok ? r_s0 : i_stat.count;

    always_comb begin
        n_state   = r_state;
        n_s       = r_s;
        n_p       = r_p;
        n_s0      = r_s0;
        n_s0_ok   = r_s0_ok;
        n_pos     = r_pos;
        n_kind    = r_kind;
        n_src     = r_src;
        o_cmd     = '0;
        o_cmd.cur_stage = r_s;
        o_in_ready = 1'b0;
        go_next   = 1'b0;
        go_absent = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_s     = '0;
                    n_p     = '0;
                    n_s0_ok = 1'b0;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (i_stat.op == OP_POP) begin
                    if (i_stat.count == '0) begin
                        n_kind  = K_EMPTY;
                        n_src   = SRC_ZERO;
                        n_state = ST_EMIT;
                    end else if (i_stat.len == '0) begin
                        o_cmd.pop_stage = 1'b1;
                        n_kind  = K_EMPTY;
                        n_src   = SRC_ZERO;
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_POP_RD;
                    end
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (r_p < i_stat.len) begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_stage = r_s;
                    o_cmd.rd_pos   = r_p;
                    n_state        = ST_SCAN_CHK;
                end else begin
                    go_absent = 1'b1;
                end
            end
            ST_SCAN_CHK: begin
                if (i_stat.stream_gt) begin
                    n_p     = r_p + LW'(1);
                    n_state = ST_SCAN_RD;
                end else if (i_stat.stream_eq) begin
                    n_pos[ix] = r_p;
                    if (!r_s0_ok && i_stat.seq_eq) begin
                        n_kind  = K_DUP;
                        n_src   = SRC_IN;
                        n_state = ST_EMIT;
                    end else begin
                        // first stored frame newer than the input starts the chain
                        if (!r_s0_ok && !i_stat.seq_gt) begin
                            n_s0    = r_s;
                            n_s0_ok = 1'b1;
                        end
                        go_next = 1'b1;
                    end
                end else begin
                    go_absent = 1'b1;
                end
            end
            ST_ALL: begin
                n_s0 = s0v;
                if (i_stat.count < i_stat.limit) begin
                    // open a new empty stage at the end
                    n_s   = i_stat.count;
                    n_pos[i_stat.count[SW-1:0]] = '0;
                    n_p   = '0;
                    n_state = ST_SH_RD;
                end else if (s0v == '0) begin
                    n_kind  = K_DROP;
                    n_src   = SRC_IN;
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_stage = '0;
                    o_cmd.rd_pos   = r_pos[0];
                    n_state        = ST_DR_LD;
                end
            end
            ST_SH_RD: begin
                if (r_p > r_pos[ix]) begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_stage = r_s;
                    o_cmd.rd_pos   = r_p - LW'(1);
                    n_state        = ST_SH_WR;
                end else begin
                    o_cmd.len_inc = 1'b1;
                    if (r_s >= i_stat.count) begin
                        o_cmd.cnt_set = 1'b1;
                    end
                    n_state = ST_MV_RD;
                end
            end
            ST_SH_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_stage = r_s;
                o_cmd.wr_pos   = r_p;
                o_cmd.wr_src   = SRC_RD;
                n_p            = r_p - LW'(1);
                n_state        = ST_SH_RD;
            end
            ST_MV_RD: begin
                if (r_s > r_s0) begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_stage = sm1;
                    o_cmd.rd_pos   = r_pos[ixm];
                    n_state        = ST_MV_WR;
                end else begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_stage = r_s;
                    o_cmd.wr_pos   = r_pos[ix];
                    o_cmd.wr_src   = SRC_IN;
                    n_kind         = K_STORED;
                    n_src          = SRC_IN;
                    n_state        = ST_EMIT;
                end
            end
            ST_MV_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_stage = r_s;
                o_cmd.wr_pos   = r_pos[ix];
                o_cmd.wr_src   = SRC_RD;
                n_s            = sm1;
                n_state        = ST_MV_RD;
            end
            ST_DR_LD: begin
                o_cmd.drop_load = 1'b1;
                n_s     = '0;
                n_state = ST_DR_RD;
            end
            ST_DR_RD: begin
                if (sp1 < r_s0) begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_stage = sp1;
                    o_cmd.rd_pos   = r_pos[ixp];
                    n_state        = ST_DR_WR;
                end else begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_stage = r_s;
                    o_cmd.wr_pos   = r_pos[ix];
                    o_cmd.wr_src   = SRC_IN;
                    n_kind         = K_DROP;
                    n_src          = SRC_DROP;
                    n_state        = ST_EMIT;
                end
            end
            ST_DR_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_stage = r_s;
                o_cmd.wr_pos   = r_pos[ix];
                o_cmd.wr_src   = SRC_RD;
                n_s            = sp1;
                n_state        = ST_DR_RD;
            end
            ST_POP_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_stage = '0;
                o_cmd.rd_pos   = r_p;
                n_state        = ST_POP_OUT;
            end
            ST_POP_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = K_REL;
                    o_cmd.out_src  = SRC_RD;
                    o_cmd.out_last = (r_p + LW'(1)) == i_stat.len;
                    if ((r_p + LW'(1)) == i_stat.len) begin
                        o_cmd.pop_stage = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_p     = r_p + LW'(1);
                        n_state = ST_POP_RD;
                    end
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = r_kind;
                    o_cmd.out_src  = r_src;
                    o_cmd.out_last = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (go_next) begin
            if (sp1 == eff) begin
                n_state = ST_ALL;
            end else begin
                n_s     = sp1;
                n_p     = '0;
                n_state = ST_SCAN_RD;
            end
        end

        // stream missing here: the chain ends with an insert, or K_FULL if full
        if (go_absent) begin
            n_pos[ix] = r_p;
            if (!r_s0_ok) begin
                n_s0 = r_s;
            end
            if (i_stat.len == LW'(MAX_STREAMS)) begin
                n_kind  = K_FULL;
                n_src   = SRC_IN;
                n_state = ST_EMIT;
            end else begin
                n_p     = i_stat.len;
                n_state = ST_SH_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_s     <= '0;
            r_p     <= '0;
            r_s0    <= '0;
            r_s0_ok <= 1'b0;
            r_kind  <= K_STORED;
            r_src   <= SRC_IN;
        end else begin
            r_state <= n_state;
            r_s     <= n_s;
            r_p     <= n_p;
            r_s0    <= n_s0;
            r_s0_ok <= n_s0_ok;
            r_kind  <= n_kind;
            r_src   <= n_src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
    end

endmodule
`default_nettype wire

// ===== rtl/rtp_stage_jitter_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake     payload
// i_in      sink       valid/ready   op, stream_id, seq_num, frame_tag
// o_out     source     valid/ready   kind, out_stream_id, out_seq_num, out_tag, last
// i_cfg     sink       valid/ready   stage_cap (ready always high)
//
// one item at a time; frames live in a single-port-read memory, one slot read per cycle
// add: a search compares slots, then slots are shifted and stages moved or shifted down
// pop: releases the frames of the head stage one by one; output register lets the
//   next item enter while the last result waits; o_out stalls hold the sequencer in place
// synchronous active-low reset empties all stages at once
module rtp_stage_jitter_buffer
    import rtpjb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    rtpjb_item_if.sink     i_in,
    rtpjb_result_if.source o_out,
    rtpjb_cfg_if.sink      i_cfg
);

    t_cmd  cmd;
    t_stat stat;

    assign i_cfg.ready = 1'b1;

    rtpjb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rtpjb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (i_in.op),
        .i_stream_id (i_in.stream_id),
        .i_seq_num   (i_in.seq_num),
        .i_frame_tag (i_in.frame_tag),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.stage_cap),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_kind      (o_out.kind),
        .o_stream_id (o_out.out_stream_id),
        .o_seq_num   (o_out.out_seq_num),
        .o_tag       (o_out.out_tag),
        .o_last      (o_out.last)
    );

endmodule
`default_nettype wire

// ===== rtl/rtpjb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtpjb_checker
    import rtpjb_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_kind,
    input wire logic [31:0] i_stream,
    input wire logic [15:0] i_seq,
    input wire logic [15:0] i_tag,
    input wire logic        i_last
);

    logic [1:0] r_open;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // transactions whose last result is not yet taken; one may wait in the
    // output register while the next one runs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 2'(in_acc) - 2'(out_acc && i_last);
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_open <= 2'd1))
        else $error("new transaction accepted while another is still running");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_open != 2'd0))
        else $error("result without open transaction");

    a_multi_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_last) |-> (i_kind == K_REL))
        else $error("non-final result that is not a release");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == K_EMPTY) |->
            (i_stream == '0 && i_seq == '0 && i_tag == '0 && i_last))
        else $error("empty pop carries a frame");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable({i_kind, i_stream, i_seq, i_tag, i_last})))
        else $error("stalled result changed");

endmodule

bind rtp_stage_jitter_buffer rtpjb_checker u_rtpjb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.kind),
    .i_stream    (o_out.out_stream_id),
    .i_seq       (o_out.out_seq_num),
    .i_tag       (o_out.out_tag),
    .i_last      (o_out.last)
);
`default_nettype wire
